### design/pjw_pkg.sv
package pjw_pkg;

    // fixed field widths
    localparam int SYM_W        = 8;
    localparam int CFG_W        = 11;
    localparam int SLOT_FIELD_W = 10;
    localparam int HASH_W       = 28;

    // table geometry
    localparam int SLOTS   = 1024;
    localparam int MAX_LEN = 45;

    localparam int SLOT_W  = $clog2(SLOTS);
    localparam int SIZE_W  = SLOT_W + 1;
    localparam int LEN_W   = $clog2(MAX_LEN + 1);
    localparam int BUF_AW  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int CHAR_AW = $clog2(SLOTS * MAX_LEN);
    localparam int DIV_CW  = $clog2(HASH_W);

    localparam logic [CFG_W-1:0] TABLE_SIZE_RESET = 11'd1024;

    localparam logic [SYM_W-1:0] CH_UPPER_A = 8'h41;
    localparam logic [SYM_W-1:0] CH_UPPER_Z = 8'h5A;
    localparam logic [SYM_W-1:0] CASE_DELTA = 8'h20;

    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_CHECK  = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV,
        ST_META,
        ST_COPY,
        ST_VERIFY,
        ST_FINISH
    } pjw_state_t;

    typedef struct packed {
        logic clear_run;
        logic take;
        logic meta_rd;
        logic meta_wr;
        logic walk_start;
        logic walk_run;
        logic copy;
        logic verify;
        logic res_load;
    } pjw_cmd_t;

    typedef struct packed {
        logic clear_done;
        logic last_taken;
        logic div_done;
        logic too_long;
        logic func_check;
        logic meta_hit;
        logic walk_done;
        logic out_free;
    } pjw_stat_t;

    typedef struct packed {
        logic             used;
        logic [LEN_W-1:0] len;
    } pjw_meta_t;

    // one PJW step on a 28-bit running hash
    function automatic logic [HASH_W-1:0] pjw_hash_step(input logic [HASH_W-1:0] h,
                                                         input logic [SYM_W-1:0] c);
        logic [31:0] w;
        logic [3:0]  top;
        begin
            w   = {h, 4'b0000} + {24'd0, c};
            top = w[31:28];
            pjw_hash_step = w[HASH_W-1:0] ^ {20'd0, top, 4'b0000};
        end
    endfunction

endpackage

### design/pjw_in_if.sv
interface pjw_in_if import pjw_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             func;
    logic [SYM_W-1:0] symbol;
    logic             last;

    modport source (output valid, output func, output symbol, output last, input ready);
    modport sink (input valid, input func, input symbol, input last, output ready);
endinterface

### design/pjw_out_if.sv
interface pjw_out_if import pjw_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic                    found;
    logic                    rejected;
    logic [SLOT_FIELD_W-1:0] slot;

    modport source (output valid, output found, output rejected, output slot, input ready);
    modport sink (input valid, input found, input rejected, input slot, output ready);
endinterface

### design/pjw_hashed_word_dictionary.sv
// Characters that are not the last of a word are taken at 1 per cycle.
// A last character starts a bit-serial remainder of the 28-bit hash, then a tag read, then a
// copy or compare of the word, one character per cycle (skipped on a check whose tag misses
// and for an over-long word), then the result load, waiting while an older result is unread.
// One word is in work at a time; no item is taken until its result is loaded.
// After reset a pass clears all 1024 slot tags; no item is taken, config writes are.
module pjw_hashed_word_dictionary import pjw_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    pjw_in_if.sink           chars,
    pjw_out_if.source        results,
    input  logic             cfg_wr_en,
    input  logic [CFG_W-1:0] cfg_wr_data
);

    pjw_cmd_t  cmd;
    pjw_stat_t st;

    pjw_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .st    (st),
        .cmd   (cmd)
    );

    pjw_dp u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .chars       (chars),
        .results     (results),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd),
        .st          (st)
    );

endmodule

### design/pjw_mod.sv
module pjw_mod import pjw_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [HASH_W-1:0] dividend,
    input  logic [SIZE_W-1:0] divisor,
    output logic              done,
    output logic [SIZE_W-1:0] rem
);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DIV_CW-1:0] cnt_reg, cnt_next;
    logic [HASH_W-1:0] dvd_reg, dvd_next;
    logic [SIZE_W-1:0] dsr_reg, dsr_next;
    logic [SIZE_W-1:0] rem_reg, rem_next;
    logic [SIZE_W:0]   trial;
    logic [SIZE_W:0]   diff;
    logic [SIZE_W-1:0] rem_step;

    // restoring remainder, one dividend bit per cycle
    always_comb
    begin
        trial    = {rem_reg, dvd_reg[HASH_W-1]};
        diff     = trial - {1'b0, dsr_reg};
        rem_step = (trial >= {1'b0, dsr_reg}) ? diff[SIZE_W-1:0] : trial[SIZE_W-1:0];
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = done_reg;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            done_next = 1'b0;
            cnt_next  = '0;
            dvd_next  = dividend;
            dsr_next  = divisor;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            rem_next = rem_step;
            dvd_next = {dvd_reg[HASH_W-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CW'(HASH_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
        rem_reg <= rem_next;
    end

    assign done = done_reg;
    assign rem  = rem_reg;

    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n) start |-> !busy_reg)
        else $error("remainder unit restarted while busy");
    a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (rem_reg < dsr_reg))
        else $error("remainder not below table size");

endmodule

### design/pjw_dp.sv
module pjw_dp import pjw_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    pjw_in_if.sink           chars,
    pjw_out_if.source        results,
    input  logic             cfg_wr_en,
    input  logic [CFG_W-1:0] cfg_wr_data,
    input  pjw_cmd_t         cmd,
    output pjw_stat_t        st
);

    logic [CFG_W-1:0]        table_size_reg;
    logic [HASH_W-1:0]       hash_reg, hash_next;
    logic [LEN_W-1:0]        len_reg, len_next;
    logic                    too_long_reg, too_long_next;
    logic                    func_check_reg, func_check_next;
    logic [SLOT_W-1:0]       clr_cnt_reg;
    logic [LEN_W-1:0]        idx_reg, idx_next;
    logic [LEN_W-1:0]        idx_d_reg;
    logic                    pv_reg, pv_next;
    logic                    mismatch_reg, mismatch_next;
    logic                    out_valid_reg, out_valid_next;
    logic                    found_reg;
    logic                    rejected_reg;
    logic [SLOT_FIELD_W-1:0] slot_out_reg;
    logic [CHAR_AW-1:0]      base_reg;
    logic [SYM_W-1:0]        buf_q_reg;
    logic [SYM_W-1:0]        chars_q_reg;
    pjw_meta_t               meta_q_reg;

    logic [SYM_W-1:0]  buf_mem [MAX_LEN];
    logic [SYM_W-1:0]  chars_mem [SLOTS * MAX_LEN];
    pjw_meta_t         meta_mem [SLOTS];

    logic              accept;
    logic [SYM_W-1:0]  sym_fold;
    logic              buf_we;
    logic [SIZE_W-1:0] size;
    logic              div_done;
    logic [SIZE_W-1:0] div_rem;
    logic [SLOT_W-1:0] slot;
    logic              issue;
    logic              meta_we;
    logic [SLOT_W-1:0] meta_addr;
    pjw_meta_t         meta_wdata;
    logic              meta_hit;

    assign chars.ready = cmd.take;
    assign accept      = chars.valid && cmd.take;

    always_comb
    begin
        sym_fold = chars.symbol;
        if (chars.func == FUNC_CHECK && (chars.symbol inside {[CH_UPPER_A:CH_UPPER_Z]}))
        begin
            sym_fold = chars.symbol + CASE_DELTA;
        end
    end

    // size clamped to 1..SLOTS
    always_comb
    begin
        if (table_size_reg == '0)
        begin
            size = SIZE_W'(1);
        end
        else if (32'(table_size_reg) > SLOTS)
        begin
            size = SIZE_W'(SLOTS);
        end
        else
        begin
            size = SIZE_W'(table_size_reg);
        end
    end

    assign buf_we = accept && (len_reg < LEN_W'(MAX_LEN));

    always_comb
    begin
        hash_next       = hash_reg;
        len_next        = len_reg;
        too_long_next   = too_long_reg;
        func_check_next = func_check_reg;
        if (cmd.res_load)
        begin
            hash_next     = '0;
            len_next      = '0;
            too_long_next = 1'b0;
        end
        else if (accept)
        begin
            hash_next = pjw_hash_step(hash_reg, sym_fold);
            if (len_reg < LEN_W'(MAX_LEN))
            begin
                len_next = len_reg + 1'b1;
            end
            else
            begin
                too_long_next = 1'b1;
            end
            if (chars.last)
            begin
                func_check_next = chars.func;
            end
        end
    end

    pjw_mod u_mod
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (accept && chars.last),
        .dividend (hash_next),
        .divisor  (size),
        .done     (div_done),
        .rem      (div_rem)
    );

    assign slot = div_rem[SLOT_W-1:0];

    // walk over the buffered word: read stage, then copy or compare stage
    assign issue = cmd.walk_run && (idx_reg < len_reg);

    always_comb
    begin
        idx_next      = idx_reg;
        pv_next       = issue;
        mismatch_next = mismatch_reg;
        if (cmd.walk_start)
        begin
            idx_next      = '0;
            mismatch_next = 1'b0;
        end
        else if (issue)
        begin
            idx_next = idx_reg + 1'b1;
        end
        if (cmd.verify && pv_reg && (buf_q_reg != chars_q_reg))
        begin
            mismatch_next = 1'b1;
        end
    end

    assign meta_hit = meta_q_reg.used && (meta_q_reg.len == len_reg);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.res_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_size_reg <= TABLE_SIZE_RESET;
            hash_reg       <= '0;
            len_reg        <= '0;
            too_long_reg   <= 1'b0;
            func_check_reg <= FUNC_INSERT;
            clr_cnt_reg    <= '0;
            idx_reg        <= '0;
            idx_d_reg      <= '0;
            pv_reg         <= 1'b0;
            mismatch_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                table_size_reg <= cfg_wr_data;
            end
            hash_reg       <= hash_next;
            len_reg        <= len_next;
            too_long_reg   <= too_long_next;
            func_check_reg <= func_check_next;
            if (cmd.clear_run)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            idx_reg       <= idx_next;
            idx_d_reg     <= idx_reg;
            pv_reg        <= pv_next;
            mismatch_reg  <= mismatch_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.res_load)
        begin
            found_reg    <= (func_check_reg == FUNC_CHECK) && !too_long_reg && meta_hit
                            && !mismatch_reg;
            rejected_reg <= too_long_reg;
            slot_out_reg <= SLOT_FIELD_W'(slot);
        end
        if (cmd.walk_start)
        begin
            base_reg <= CHAR_AW'(32'(slot) * MAX_LEN);
        end
    end

    // word buffer
    always_ff @(posedge clk)
    begin
        if (buf_we)
        begin
            buf_mem[len_reg[BUF_AW-1:0]] <= sym_fold;
        end
        if (issue)
        begin
            buf_q_reg <= buf_mem[idx_reg[BUF_AW-1:0]];
        end
    end

    // stored words
    always_ff @(posedge clk)
    begin
        if (cmd.copy && pv_reg)
        begin
            chars_mem[base_reg + CHAR_AW'(idx_d_reg)] <= buf_q_reg;
        end
        if (issue)
        begin
            chars_q_reg <= chars_mem[base_reg + CHAR_AW'(idx_reg)];
        end
    end

    // slot tags: used flag and length
    assign meta_we    = cmd.clear_run || cmd.meta_wr;
    assign meta_addr  = cmd.clear_run ? clr_cnt_reg : slot;
    assign meta_wdata = cmd.clear_run ? '0 : pjw_meta_t'{used: 1'b1, len: len_reg};

    always_ff @(posedge clk)
    begin
        if (meta_we)
        begin
            meta_mem[meta_addr] <= meta_wdata;
        end
        if (cmd.meta_rd)
        begin
            meta_q_reg <= meta_mem[meta_addr];
        end
    end

    assign results.valid    = out_valid_reg;
    assign results.found    = found_reg;
    assign results.rejected = rejected_reg;
    assign results.slot     = slot_out_reg;

    always_comb
    begin
        st.clear_done = (clr_cnt_reg == SLOT_W'(SLOTS - 1));
        st.last_taken = accept && chars.last;
        st.div_done   = div_done;
        st.too_long   = too_long_reg;
        st.func_check = (func_check_reg == FUNC_CHECK);
        st.meta_hit   = meta_hit;
        st.walk_done  = (idx_reg == len_reg) && !pv_reg;
        st.out_free   = !out_valid_reg || results.ready;
    end

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.res_load |-> (!out_valid_reg || results.ready))
        else $error("result register overwritten before it was taken");

endmodule

### design/pjw_ctrl.sv
module pjw_ctrl import pjw_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  pjw_stat_t st,
    output pjw_cmd_t  cmd
);

    pjw_state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (st.clear_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (st.last_taken)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (st.div_done)
                begin
                    state_next = ST_META;
                end
            end
            ST_META:
            begin
                if (st.too_long)
                begin
                    state_next = ST_FINISH;
                end
                else if (st.func_check)
                begin
                    state_next = ST_VERIFY;
                end
                else
                begin
                    state_next = ST_COPY;
                end
            end
            ST_COPY:
            begin
                if (st.walk_done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_VERIFY:
            begin
                if (!st.meta_hit || st.walk_done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (st.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd            = '0;
        cmd.clear_run  = (state_reg == ST_CLEAR);
        cmd.take       = (state_reg == ST_IDLE);
        cmd.meta_rd    = (state_reg == ST_META);
        cmd.meta_wr    = (state_reg == ST_META) && !st.too_long && !st.func_check;
        cmd.walk_start = (state_reg == ST_META);
        cmd.walk_run   = (state_reg == ST_COPY) || ((state_reg == ST_VERIFY) && st.meta_hit);
        cmd.copy       = (state_reg == ST_COPY);
        cmd.verify     = (state_reg == ST_VERIFY);
        cmd.res_load   = (state_reg == ST_FINISH) && st.out_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_last_to_div: assert property (@(posedge clk) disable iff (!rst_n)
        st.last_taken |=> (state_reg == ST_DIV))
        else $error("last item of a word did not start the slot computation");

endmodule

### sim/pjw_hashed_word_dictionary_test.sv
`timescale 1ns / 100ps

module pjw_hashed_word_dictionary_test;
    import pjw_pkg::*;

    localparam int SETTLE_CYCLES = 100;
    localparam int STYLE_LOWER   = 0;
    localparam int STYLE_LETTERS = 1;
    localparam int STYLE_BYTES   = 2;
    localparam int SAVED_WORDS   = 64;
    localparam int RANDOM_PHASES = 7;

    typedef struct packed {
        logic             func;
        logic [SYM_W-1:0] symbol;
        logic             last;
    } char_item_t;

    typedef struct packed {
        logic                    found;
        logic                    rejected;
        logic [SLOT_FIELD_W-1:0] slot;
    } lookup_result_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_wr_en;
    logic [CFG_W-1:0] cfg_wr_data;

    pjw_in_if  chars_if ();
    pjw_out_if results_if ();

    pjw_hashed_word_dictionary dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .chars       (chars_if),
        .results     (results_if),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always #5 clk = ~clk;

    // dictionary model
    logic [CFG_W-1:0]  table_slots;
    logic [HASH_W-1:0] word_hash;
    logic [SYM_W-1:0]  word_chars [MAX_LEN];
    int                word_len;
    logic              word_overflow;
    logic [SYM_W-1:0]  stored_chars [SLOTS][MAX_LEN];
    int                stored_len [SLOTS];
    logic              stored_valid [SLOTS];

    lookup_result_t pending_lookups [$];
    char_item_t     char_queue [$];
    char_item_t     on_bus;
    lookup_result_t want;

    int queued_chars;
    int accepted_chars;
    int errors;
    int send_gap_pct;
    int recv_gap_pct;

    // word generation scratch and a ring of inserted words to look up again
    logic [SYM_W-1:0] build_chars [64];
    logic [SYM_W-1:0] saved_chars [SAVED_WORDS][MAX_LEN];
    int               saved_len [SAVED_WORDS];
    int               saved_count;
    int               saved_head;

    function automatic logic [HASH_W-1:0] next_hash(input logic [HASH_W-1:0] h,
                                                    input logic [SYM_W-1:0] c);
        logic [31:0] sum;
        begin
            sum = {h, 4'h0} + {24'h0, c};
            // fold the high nibble back into bits 7:4, then drop it
            if (sum[31:28] != 4'h0)
                sum = sum ^ {24'h0, sum[31:28], 4'h0};
            return sum[HASH_W-1:0];
        end
    endfunction

    function automatic void absorb_char(input char_item_t it);
        logic [SYM_W-1:0] c;
        int unsigned size;
        int unsigned slot;
        logic hit;
        begin
            c = it.symbol;
            if (it.func == FUNC_CHECK && c >= CH_UPPER_A && c <= CH_UPPER_Z)
                c = c + CASE_DELTA;
            word_hash = next_hash(word_hash, c);
            if (word_len < MAX_LEN)
            begin
                word_chars[word_len] = c;
                word_len++;
            end
            else
                word_overflow = 1'b1;
            if (it.last)
            begin
                size = table_slots;
                if (size < 1)
                    size = 1;
                if (size > SLOTS)
                    size = SLOTS;
                slot = word_hash % size;
                hit = 1'b0;
                if (!word_overflow)
                begin
                    if (it.func == FUNC_INSERT)
                    begin
                        for (int i = 0; i < word_len; i++)
                            stored_chars[slot][i] = word_chars[i];
                        stored_len[slot] = word_len;
                        stored_valid[slot] = 1'b1;
                    end
                    else if (stored_valid[slot] && stored_len[slot] == word_len)
                    begin
                        hit = 1'b1;
                        for (int i = 0; i < word_len; i++)
                            if (stored_chars[slot][i] != word_chars[i])
                                hit = 1'b0;
                    end
                end
                pending_lookups.push_back('{found: hit, rejected: word_overflow,
                                            slot: SLOT_FIELD_W'(slot)});
                word_hash = '0;
                word_len = 0;
                word_overflow = 1'b0;
            end
        end
    endfunction

    function automatic void push_char(input logic fn, input logic [SYM_W-1:0] sym,
                                      input logic lst);
        char_item_t it;
        begin
            it.func = fn;
            it.symbol = sym;
            it.last = lst;
            char_queue.push_back(it);
            queued_chars++;
        end
    endfunction

    function automatic void push_word(input logic fn, input int len, input bit mix);
        logic f;
        begin
            for (int i = 0; i < len; i++)
            begin
                f = (mix && i != len - 1) ? 1'($urandom_range(1)) : fn;
                push_char(f, build_chars[i], i == len - 1);
            end
        end
    endfunction

    function automatic int set_chars(input string s);
        begin
            for (int i = 0; i < s.len(); i++)
                build_chars[i] = s[i];
            return s.len();
        end
    endfunction

    function automatic void fill_word(input int len, input int style);
        begin
            for (int i = 0; i < len; i++)
                case (style)
                    STYLE_LOWER:   build_chars[i] = 8'h61 + 8'($urandom_range(7));
                    STYLE_LETTERS: build_chars[i] = ($urandom_range(1) ? 8'h61 : CH_UPPER_A)
                                                    + 8'($urandom_range(3));
                    default:       build_chars[i] = 8'($urandom_range(255));
                endcase
        end
    endfunction

    function automatic int short_len();
        begin
            if ($urandom_range(9) != 0)
                return $urandom_range(6, 1);
            if ($urandom_range(3) == 0)
                return MAX_LEN;
            return $urandom_range(MAX_LEN, 7);
        end
    endfunction

    function automatic void remember_word(input int len);
        begin
            for (int i = 0; i < len; i++)
                saved_chars[saved_head][i] = build_chars[i];
            saved_len[saved_head] = len;
            saved_head = (saved_head + 1) % SAVED_WORDS;
            if (saved_count < SAVED_WORDS)
                saved_count++;
        end
    endfunction

    // copy back an inserted word; mangle upper-cases some lowercase letters
    function automatic int recall_word(input bit mangle);
        int idx;
        logic [SYM_W-1:0] c;
        begin
            idx = $urandom_range(saved_count - 1);
            for (int i = 0; i < saved_len[idx]; i++)
            begin
                c = saved_chars[idx][i];
                if (mangle && c >= 8'h61 && c <= 8'h7A && $urandom_range(1))
                    c = c - CASE_DELTA;
                build_chars[i] = c;
            end
            return saved_len[idx];
        end
    endfunction

    function automatic void add_random_word();
        int pick;
        int len;
        begin
            pick = $urandom_range(99);
            if (pick < 30 || saved_count == 0)
            begin
                len = short_len();
                fill_word(len, ($urandom_range(9) == 0) ? STYLE_BYTES : STYLE_LOWER);
                push_word(FUNC_INSERT, len, 1'b0);
                remember_word(len);
            end
            else if (pick < 62)
            begin
                len = recall_word(1'b1);
                push_word(FUNC_CHECK, len, 1'b0);
            end
            else if (pick < 70)
            begin
                len = recall_word($urandom_range(3) == 0);
                push_word(FUNC_INSERT, len, 1'b0);
            end
            else if (pick < 80)
            begin
                len = short_len();
                fill_word(len, STYLE_LETTERS);
                push_word(FUNC_CHECK, len, 1'b0);
            end
            else if (pick < 88)
            begin
                len = short_len();
                fill_word(len, STYLE_LETTERS);
                push_word(1'($urandom_range(1)), len, 1'b1);
            end
            else if (pick < 97)
            begin
                len = $urandom_range(4, 1);
                fill_word(len, STYLE_BYTES);
                push_word(1'($urandom_range(1)), len, 1'($urandom_range(1)));
            end
            else
            begin
                len = $urandom_range(MAX_LEN + 3, MAX_LEN + 1);
                fill_word(len, STYLE_LETTERS);
                push_word(1'($urandom_range(1)), len, 1'b0);
            end
        end
    endfunction

    task automatic load_table_size(input logic [CFG_W-1:0] value);
        begin
            @(posedge clk);
            cfg_wr_en <= 1'b1;
            cfg_wr_data <= value;
            table_slots = value;
            @(posedge clk);
            cfg_wr_en <= 1'b0;
        end
    endtask

    task automatic drain_block();
        begin
            do
                @(posedge clk);
            while (accepted_chars != queued_chars || pending_lookups.size() != 0);
            repeat (SETTLE_CYCLES) @(posedge clk);
        end
    endtask

    // character driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (chars_if.valid && chars_if.ready)
            begin
                absorb_char(on_bus);
                accepted_chars++;
            end
            if (!chars_if.valid || chars_if.ready)
            begin
                if (char_queue.size() != 0 && $urandom_range(99) >= send_gap_pct)
                begin
                    on_bus = char_queue.pop_front();
                    chars_if.valid <= 1'b1;
                    chars_if.func <= on_bus.func;
                    chars_if.symbol <= on_bus.symbol;
                    chars_if.last <= on_bus.last;
                end
                else
                    chars_if.valid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (results_if.valid && results_if.ready)
            begin
                if (pending_lookups.size() == 0)
                begin
                    $display("%0t: unexpected item found=%0b rejected=%0b slot=%0d", $time,
                             results_if.found, results_if.rejected, results_if.slot);
                    errors++;
                end
                else
                begin
                    want = pending_lookups.pop_front();
                    if (results_if.found !== want.found)
                    begin
                        $display("%0t: found expected %0b actual %0b", $time, want.found,
                                 results_if.found);
                        errors++;
                    end
                    if (results_if.rejected !== want.rejected)
                    begin
                        $display("%0t: rejected expected %0b actual %0b", $time,
                                 want.rejected, results_if.rejected);
                        errors++;
                    end
                    if (results_if.slot !== want.slot)
                    begin
                        $display("%0t: slot expected %0d actual %0d", $time, want.slot,
                                 results_if.slot);
                        errors++;
                    end
                end
            end
            results_if.ready <= ($urandom_range(99) >= recv_gap_pct);
        end
    end

    initial
    begin
        int len;
        int budget;
        logic [CFG_W-1:0] phase_size [RANDOM_PHASES];

        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        chars_if.valid = 1'b0;
        chars_if.func = FUNC_INSERT;
        chars_if.symbol = '0;
        chars_if.last = 1'b0;
        results_if.ready = 1'b0;

        table_slots = TABLE_SIZE_RESET;
        word_hash = '0;
        word_len = 0;
        word_overflow = 1'b0;
        for (int i = 0; i < SLOTS; i++)
            stored_valid[i] = 1'b0;
        queued_chars = 0;
        accepted_chars = 0;
        errors = 0;
        saved_count = 0;
        saved_head = 0;
        send_gap_pct = 12;
        recv_gap_pct = 52;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // directed words at the reset table size
        len = set_chars("ab");
        push_word(FUNC_INSERT, len, 1'b0);
        len = set_chars("AB");
        push_word(FUNC_CHECK, len, 1'b0);
        push_char(FUNC_INSERT, 8'h00, 1'b1);
        push_char(FUNC_CHECK, 8'h00, 1'b1);
        push_char(FUNC_INSERT, 8'hFF, 1'b0);
        push_char(FUNC_INSERT, CH_UPPER_A, 1'b1);
        // same bytes, but the check folds the 'A'
        push_char(FUNC_CHECK, 8'hFF, 1'b0);
        push_char(FUNC_CHECK, CH_UPPER_A, 1'b1);
        // func changes inside the word
        push_char(FUNC_CHECK, 8'h51, 1'b0);
        push_char(FUNC_INSERT, 8'h78, 1'b1);
        len = set_chars("zz");
        push_word(FUNC_CHECK, len, 1'b0);
        // neighbors of the upper-case range
        len = set_chars("@[ZA");
        push_word(FUNC_INSERT, len, 1'b0);
        push_word(FUNC_CHECK, len, 1'b0);
        drain_block();

        phase_size[0] = 11'd0;
        phase_size[1] = 11'd2047;
        phase_size[2] = 11'd1;
        phase_size[3] = 11'd13;
        phase_size[4] = 11'd1025;
        phase_size[5] = CFG_W'($urandom_range(1024, 2));
        phase_size[6] = 11'd1024;

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            if (p == 3)
            begin
                send_gap_pct = 52;
                recv_gap_pct = 12;
            end
            else if (p == 5)
            begin
                send_gap_pct = 0;
                recv_gap_pct = 0;
            end
            load_table_size(phase_size[p]);
            budget = queued_chars + 135;
            while (queued_chars < budget)
                add_random_word();
            drain_block();
        end

        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #6_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
